/* hdl/rectchk_pkg.sv */
// rectchk_pkg: shared types, register codes and the overlap test
// for the rectangle overlap and bounds checker
// no dependencies
package rectchk_pkg;

  localparam int COORD_W  = 15;
  localparam int POS_W    = 16;
  localparam int SHEET_W  = 16;
  localparam int IDX_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SHEET_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_HEIGHT = 1'd1;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic RES_COLLISION = 1'b0;
  localparam logic RES_STATUS    = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } rect_t;

  // strict half-open overlap of two rectangles
  function automatic logic overlaps(input rect_t a, input rect_t b);
    logic [COORD_W:0] a_xe;
    logic [COORD_W:0] a_ye;
    logic [COORD_W:0] b_xe;
    logic [COORD_W:0] b_ye;
    a_xe = {1'b0, a.x} + {1'b0, a.w};
    a_ye = {1'b0, a.y} + {1'b0, a.h};
    b_xe = {1'b0, b.x} + {1'b0, b.w};
    b_ye = {1'b0, b.y} + {1'b0, b.h};
    return ({1'b0, a.x} < b_xe) && ({1'b0, b.x} < a_xe) &&
           ({1'b0, a.y} < b_ye) && ({1'b0, b.y} < a_ye);
  endfunction

endpackage

/* hdl/rectchk_mem.sv */
// rectchk_mem: rectangle table, one write port and one read port
// with registered read data; depends on rectchk_pkg
module rectchk_mem #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  rectchk_pkg::rect_t         wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output rectchk_pkg::rect_t         rd_data
);

  rectchk_pkg::rect_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/rectangle_overlap_and_bounds_checker.sv */
// rectangle_overlap_and_bounds_checker: top level with the scan sequencer
// and the output register; depends on rectchk_pkg and rectchk_mem
//
// Usage:
//   input channel (in_valid/in_stall) carries one request per rectangle or
//   clear. An add request is checked against the sheet size and against
//   every stored rectangle, one table read per cycle. Each overlapping
//   earlier rectangle gives a collision result on the output channel
//   (out_valid/out_stall), in table order, then one status result with
//   last set. A stored rectangle takes the next free table slot.
//   Clear, unplaced and full-table requests give only the status result.
//   A clear, unplaced or full request, or an add to an empty table, goes
//   from idle straight to the status state; an add with entries stored
//   scans the table first. A new request is taken only after the status
//   result is registered; the single table read port sets the scan pace.
//   A stalled output holds its result; the scan waits on a hit while the
//   output register is occupied. Sheet size registers are written through
//   the cfg channel (always ready); the user must write them only while
//   idle, which the block itself does not enforce.
//   Reset empties the table (count to zero), sets the sheet to 1024 by 1024
//   and drops any pending result.
module rectangle_overlap_and_bounds_checker #(
  parameter int MAX_RECTS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  kind,
  input  logic signed [rectchk_pkg::POS_W-1:0]  pos_x,
  input  logic signed [rectchk_pkg::POS_W-1:0]  pos_y,
  input  logic [rectchk_pkg::COORD_W-1:0]       rect_width,
  input  logic [rectchk_pkg::COORD_W-1:0]       rect_height,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  result_kind,
  output logic [rectchk_pkg::IDX_W-1:0]         earlier_index,
  output logic [rectchk_pkg::IDX_W-1:0]         new_index,
  output logic                                  out_of_bounds,
  output logic                                  was_stored,
  output logic                                  table_full,
  output logic                                  last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rectchk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rectchk_pkg::SHEET_W-1:0]       cfg_data
);

  localparam int AW = $clog2(MAX_RECTS);
  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_RECTS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_STATUS = 2'd2;

  logic [1:0]                          state;
  logic [CW-1:0]                       count;
  logic [CW-1:0]                       idx;
  logic [AW-1:0]                       rd_idx;
  logic                                rd_pend;
  rectchk_pkg::rect_t                  cur;
  logic [rectchk_pkg::SHEET_W-1:0]     sheet_width;
  logic [rectchk_pkg::SHEET_W-1:0]     sheet_height;
  logic                                st_oob;
  logic                                st_stored;
  logic                                st_full;

  logic                                out_free;
  logic                                in_accept;
  logic                                hit;
  logic                                advance;
  logic                                more;
  logic                                rd_en;
  logic                                wr_en;
  rectchk_pkg::rect_t                  rd_data;
  rectchk_pkg::rect_t                  in_rect;
  logic                                in_oob;
  logic [rectchk_pkg::COORD_W+1:0]     x_end;
  logic [rectchk_pkg::COORD_W+1:0]     y_end;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign in_rect.x = pos_x[rectchk_pkg::COORD_W-1:0];
  assign in_rect.y = pos_y[rectchk_pkg::COORD_W-1:0];
  assign in_rect.w = rect_width;
  assign in_rect.h = rect_height;

  assign x_end  = {2'b00, in_rect.x} + {2'b00, rect_width};
  assign y_end  = {2'b00, in_rect.y} + {2'b00, rect_height};
  assign in_oob = (x_end > {1'b0, sheet_width}) || (y_end > {1'b0, sheet_height});

  assign hit     = rd_pend && rectchk_pkg::overlaps(rd_data, cur);
  assign advance = (state == ST_SCAN) && (!hit || out_free);
  assign more    = (idx < count);
  assign rd_en   = advance && more;
  assign wr_en   = (state == ST_STATUS) && out_free && st_stored;

  rectchk_mem #(
    .DEPTH(MAX_RECTS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[AW-1:0]),
    .wr_data(cur),
    .rd_en  (rd_en),
    .rd_addr(idx[AW-1:0]),
    .rd_data(rd_data)
  );

  // sheet size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_width  <= rectchk_pkg::SHEET_W'(1024);
      sheet_height <= rectchk_pkg::SHEET_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rectchk_pkg::REG_SHEET_WIDTH:  sheet_width  <= cfg_data;
        rectchk_pkg::REG_SHEET_HEIGHT: sheet_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            cur       <= in_rect;
            st_oob    <= 1'b0;
            st_stored <= 1'b0;
            st_full   <= 1'b0;
            idx       <= '0;
            rd_pend   <= 1'b0;
            if (kind == rectchk_pkg::KIND_CLEAR) begin
              count <= '0;
              state <= ST_STATUS;
            end else if (pos_x[rectchk_pkg::POS_W-1] || pos_y[rectchk_pkg::POS_W-1]) begin
              state <= ST_STATUS;
            end else if (count >= MAX_COUNT) begin
              st_oob  <= in_oob;
              st_full <= 1'b1;
              state   <= ST_STATUS;
            end else begin
              st_oob    <= in_oob;
              st_stored <= 1'b1;
              state     <= (count == '0) ? ST_STATUS : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (advance) begin
            if (more) begin
              rd_idx  <= idx[AW-1:0];
              idx     <= idx + CW'(1);
              rd_pend <= 1'b1;
            end else begin
              rd_pend <= 1'b0;
              state   <= ST_STATUS;
            end
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            if (st_stored) begin
              count <= count + CW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_SCAN && advance && hit) begin
      out_valid     <= 1'b1;
      result_kind   <= rectchk_pkg::RES_COLLISION;
      earlier_index <= rectchk_pkg::IDX_W'(rd_idx);
      new_index     <= rectchk_pkg::IDX_W'(count);
      out_of_bounds <= 1'b0;
      was_stored    <= 1'b0;
      table_full    <= 1'b0;
      last          <= 1'b0;
    end else if (state == ST_STATUS && out_free) begin
      out_valid     <= 1'b1;
      result_kind   <= rectchk_pkg::RES_STATUS;
      earlier_index <= '0;
      new_index     <= st_stored ? rectchk_pkg::IDX_W'(count) : '0;
      out_of_bounds <= st_oob;
      was_stored    <= st_stored;
      table_full    <= st_full;
      last          <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/rectchk_check.sv */
// rectchk_check: port-level assertions for the rectangle overlap and
// bounds checker, bound to the top level; depends on rectchk_pkg
module rectchk_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              result_kind,
  input logic [rectchk_pkg::IDX_W-1:0]     earlier_index,
  input logic [rectchk_pkg::IDX_W-1:0]     new_index,
  input logic                              out_of_bounds,
  input logic                              was_stored,
  input logic                              table_full,
  input logic                              last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) &&
    $stable(earlier_index) && $stable(new_index) && $stable(last))
    else $error("stalled result changed");

  // collision results carry no status flags
  a_collision_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == rectchk_pkg::RES_COLLISION) |->
    !last && !was_stored && !table_full && !out_of_bounds)
    else $error("collision result with status flags");

  // status result ends each request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == rectchk_pkg::RES_STATUS) |->
    last && (earlier_index == '0) && !(was_stored && table_full))
    else $error("bad status result");

  // dropped rectangle gets no slot
  a_full_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> (new_index == '0))
    else $error("dropped rectangle given an index");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

endmodule

bind rectangle_overlap_and_bounds_checker rectchk_check u_check (.*);

/* tb/rect_overlap_monitor.sv */
`timescale 1ns / 100ps
// rect_overlap_monitor: watches the request, result and register channels of the
// rectangle overlap and bounds checker, predicts every result and compares it
// depends on rectchk_pkg for widths, register codes and the rectangle type
module rect_overlap_monitor #(
  parameter int MAX_RECTS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 kind,
  input  logic signed [rectchk_pkg::POS_W-1:0] pos_x,
  input  logic signed [rectchk_pkg::POS_W-1:0] pos_y,
  input  logic [rectchk_pkg::COORD_W-1:0]      rect_width,
  input  logic [rectchk_pkg::COORD_W-1:0]      rect_height,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic                                 result_kind,
  input  logic [rectchk_pkg::IDX_W-1:0]        earlier_index,
  input  logic [rectchk_pkg::IDX_W-1:0]        new_index,
  input  logic                                 out_of_bounds,
  input  logic                                 was_stored,
  input  logic                                 table_full,
  input  logic                                 last,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [rectchk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rectchk_pkg::SHEET_W-1:0]      cfg_data,
  output int                                   fails,
  output int                                   pending
);

  typedef struct packed {
    logic                          rkind;
    logic [rectchk_pkg::IDX_W-1:0] earlier;
    logic [rectchk_pkg::IDX_W-1:0] newi;
    logic                          oob;
    logic                          stored;
    logic                          full;
    logic                          fin;
  } verdict_t;

  verdict_t                        awaited_verdicts[$];
  rectchk_pkg::rect_t              placed_rects[MAX_RECTS];
  int                              placed_cnt = 0;
  logic [rectchk_pkg::SHEET_W-1:0] sheet_w = 16'd1024;
  logic [rectchk_pkg::SHEET_W-1:0] sheet_h = 16'd1024;
  int                              fail_count = 0;
  verdict_t                        got;
  verdict_t                        want;

  assign fails = fail_count;

  function automatic bit rects_meet(input rectchk_pkg::rect_t a, input rectchk_pkg::rect_t b);
    return int'(a.x) < int'(b.x) + int'(b.w) && int'(b.x) < int'(a.x) + int'(a.w) &&
           int'(a.y) < int'(b.y) + int'(b.h) && int'(b.y) < int'(a.y) + int'(a.h);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic void queue_verdict(input verdict_t v);
    awaited_verdicts = {awaited_verdicts, v};
  endfunction

  task automatic predict_verdicts(input logic k,
                                  input logic signed [rectchk_pkg::POS_W-1:0] px,
                                  input logic signed [rectchk_pkg::POS_W-1:0] py,
                                  input logic [rectchk_pkg::COORD_W-1:0] w,
                                  input logic [rectchk_pkg::COORD_W-1:0] h);
    verdict_t           v;
    verdict_t           c;
    rectchk_pkg::rect_t cur;
    bit                 oob;
    v = '0;
    v.rkind = rectchk_pkg::RES_STATUS;
    v.fin = 1'b1;
    if (k == rectchk_pkg::KIND_CLEAR) begin
      placed_cnt = 0;
      queue_verdict(v);
      return;
    end
    // unplaced rectangle
    if (px[rectchk_pkg::POS_W-1] || py[rectchk_pkg::POS_W-1]) begin
      queue_verdict(v);
      return;
    end
    cur.x = px[rectchk_pkg::COORD_W-1:0];
    cur.y = py[rectchk_pkg::COORD_W-1:0];
    cur.w = w;
    cur.h = h;
    oob = (int'(cur.x) + int'(cur.w) > int'(sheet_w)) ||
          (int'(cur.y) + int'(cur.h) > int'(sheet_h));
    v.oob = oob;
    if (placed_cnt >= MAX_RECTS) begin
      v.full = 1'b1;
      queue_verdict(v);
      return;
    end
    for (int i = 0; i < placed_cnt; i++) begin
      if (rects_meet(placed_rects[i], cur)) begin
        c = '0;
        c.rkind = rectchk_pkg::RES_COLLISION;
        c.earlier = rectchk_pkg::IDX_W'(i);
        c.newi = rectchk_pkg::IDX_W'(placed_cnt);
        queue_verdict(c);
      end
    end
    placed_rects[placed_cnt] = cur;
    v.newi = rectchk_pkg::IDX_W'(placed_cnt);
    v.stored = 1'b1;
    queue_verdict(v);
    placed_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      placed_cnt = 0;
      sheet_w = 16'd1024;
      sheet_h = 16'd1024;
      awaited_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {result_kind, earlier_index, new_index, out_of_bounds, was_stored,
               table_full, last};
        if (awaited_verdicts.size() == 0) begin
          $error("result with no request pending: kind %0d earlier %0d new %0d",
                 result_kind, earlier_index, new_index);
          fail_count++;
        end else begin
          want = awaited_verdicts.pop_front();
          check_field("result_kind", 8'(want.rkind), 8'(got.rkind));
          check_field("earlier_index", 8'(want.earlier), 8'(got.earlier));
          check_field("new_index", 8'(want.newi), 8'(got.newi));
          check_field("out_of_bounds", 8'(want.oob), 8'(got.oob));
          check_field("was_stored", 8'(want.stored), 8'(got.stored));
          check_field("table_full", 8'(want.full), 8'(got.full));
          check_field("last", 8'(want.fin), 8'(got.fin));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rectchk_pkg::REG_SHEET_WIDTH) begin
          sheet_w = cfg_data;
        end else if (cfg_index == rectchk_pkg::REG_SHEET_HEIGHT) begin
          sheet_h = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        predict_verdicts(kind, pos_x, pos_y, rect_width, rect_height);
      end
    end
    pending <= awaited_verdicts.size();
  end

endmodule

/* tb/tb_rectangle_overlap_and_bounds_checker.sv */
`timescale 1ns / 100ps
// tb_rectangle_overlap_and_bounds_checker: drives requests, register writes and
// output stalls into the block; depends on rectchk_pkg, the block and rect_overlap_monitor
module tb_rectangle_overlap_and_bounds_checker;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic                                 kind = 1'b0;
  logic signed [rectchk_pkg::POS_W-1:0] pos_x = '0;
  logic signed [rectchk_pkg::POS_W-1:0] pos_y = '0;
  logic [rectchk_pkg::COORD_W-1:0]      rect_width = '0;
  logic [rectchk_pkg::COORD_W-1:0]      rect_height = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic                                 result_kind;
  logic [rectchk_pkg::IDX_W-1:0]        earlier_index;
  logic [rectchk_pkg::IDX_W-1:0]        new_index;
  logic                                 out_of_bounds;
  logic                                 was_stored;
  logic                                 table_full;
  logic                                 last;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [rectchk_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [rectchk_pkg::SHEET_W-1:0]      cfg_data = '0;

  int fails;
  int pending;
  int cycles = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  bit calm = 1'b0;
  int sheet_w_set = 1024;
  int sheet_h_set = 1024;

  rectangle_overlap_and_bounds_checker dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .pos_x(pos_x), .pos_y(pos_y),
    .rect_width(rect_width), .rect_height(rect_height),
    .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
    .earlier_index(earlier_index), .new_index(new_index), .out_of_bounds(out_of_bounds),
    .was_stored(was_stored), .table_full(table_full), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rect_overlap_monitor monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .pos_x(pos_x), .pos_y(pos_y),
    .rect_width(rect_width), .rect_height(rect_height),
    .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
    .earlier_index(earlier_index), .new_index(new_index), .out_of_bounds(out_of_bounds),
    .was_stored(was_stored), .table_full(table_full), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 13);
    end
  end

  function automatic int to_pos(input int v);
    return v < 0 ? 0 : (v > 32767 ? 32767 : v);
  endfunction

  task automatic offer(input logic k, input int x, input int y, input int w, input int h);
    if (!calm && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    pos_x <= rectchk_pkg::POS_W'(x);
    pos_y <= rectchk_pkg::POS_W'(y);
    rect_width <= rectchk_pkg::COORD_W'(w);
    rect_height <= rectchk_pkg::COORD_W'(h);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_random(input bit allow_clear);
    int pick;
    int x;
    int y;
    int w;
    int h;
    pick = $urandom_range(0, 99);
    x = $urandom_range(0, 80);
    y = $urandom_range(0, 80);
    w = $urandom_range(0, 40);
    h = $urandom_range(0, 40);
    if (allow_clear && pick < 4) begin
      offer(rectchk_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 11) begin
      if ($urandom_range(0, 1)) begin
        x = -int'($urandom_range(1, 32768));
      end else begin
        y = -int'($urandom_range(1, 32768));
      end
      offer(rectchk_pkg::KIND_ADD, x, y, $urandom, $urandom);
    end else if (pick < 75) begin
      offer(rectchk_pkg::KIND_ADD, x, y, w, h);
    end else if (pick < 90) begin
      // straddle the sheet border
      if ($urandom_range(0, 1)) begin
        x = to_pos(sheet_w_set - int'($urandom_range(0, 40)));
      end else begin
        y = to_pos(sheet_h_set - int'($urandom_range(0, 40)));
      end
      offer(rectchk_pkg::KIND_ADD, x, y, $urandom_range(0, 60), $urandom_range(0, 60));
    end else if (pick < 95) begin
      offer(rectchk_pkg::KIND_ADD, $urandom_range(0, 32767), $urandom_range(0, 32767),
            $urandom, $urandom);
    end else begin
      offer(rectchk_pkg::KIND_ADD, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_sheet(input int w, input int h);
    sheet_w_set = w;
    sheet_h_set = h;
    cfg_valid <= 1'b1;
    cfg_index <= rectchk_pkg::REG_SHEET_WIDTH;
    cfg_data <= rectchk_pkg::SHEET_W'(w);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= rectchk_pkg::REG_SHEET_HEIGHT;
    cfg_data <= rectchk_pkg::SHEET_W'(h);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: edges, touching sides, zero size, sheet border, unplaced, clear
    offer(rectchk_pkg::KIND_ADD, 0, 0, 10, 10);
    offer(rectchk_pkg::KIND_ADD, 5, 5, 10, 10);
    offer(rectchk_pkg::KIND_ADD, 10, 0, 5, 5);
    offer(rectchk_pkg::KIND_ADD, 0, 10, 10, 10);
    offer(rectchk_pkg::KIND_ADD, 3, 3, 0, 0);
    offer(rectchk_pkg::KIND_ADD, 1014, 0, 10, 10);
    offer(rectchk_pkg::KIND_ADD, 1015, 0, 10, 10);
    offer(rectchk_pkg::KIND_ADD, 0, 1015, 0, 10);
    offer(rectchk_pkg::KIND_ADD, 32767, 32767, 32767, 32767);
    offer(rectchk_pkg::KIND_ADD, 0, 0, 32767, 32767);
    offer(rectchk_pkg::KIND_ADD, -1, 0, 4, 4);
    offer(rectchk_pkg::KIND_ADD, 0, -32768, 4, 4);
    offer(rectchk_pkg::KIND_ADD, -32768, -1, 32767, 32767);
    offer(rectchk_pkg::KIND_CLEAR, 32767, -1, 32767, 32767);
    offer(rectchk_pkg::KIND_ADD, 0, 0, 1, 1);
    offer(rectchk_pkg::KIND_CLEAR, 0, 0, 0, 0);
    drain();

    write_sheet(0, 0);
    repeat (30) offer_random(1'b1);
    drain();

    calm = 1'b1;
    write_sheet(65535, 65535);
    repeat (60) offer_random(1'b1);
    drain();
    calm = 1'b0;

    // fill the table to the top under a long result hold-off
    write_sheet(200, 150);
    offer(rectchk_pkg::KIND_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < 70; i++) begin
      if (i == 10) begin
        hold_reqs <= hold_reqs + 1;
      end
      offer_random(1'b0);
    end
    drain();

    write_sheet($urandom_range(0, 65535), $urandom_range(0, 65535));
    repeat (110) offer_random(1'b1);
    drain();

    write_sheet(32767, 1);
    for (int i = 0; i < 80; i++) begin
      if (i == 30) begin
        hold_reqs <= hold_reqs + 1;
      end
      offer_random(1'b1);
    end
    drain();

    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
